// ===== design/bbd_pkg.sv =====
// bbd_pkg: shared types and constants for the binary to decimal ascii unit
// no dependencies; imported by the interfaces, the dabble core and the top level
`timescale 1ns / 1ps

package bbd_pkg;

  localparam int IN_W   = 64;
  localparam int CHAR_W = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } bbd_state_t;

  // commands from the sequencer to the dabble core
  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } bbd_ctrl_t;

endpackage

// ===== design/bbd_ifs.sv =====
// bbd_ifs: valid/ready channel interfaces for the input value and output characters
// depends on bbd_pkg for field widths
`timescale 1ns / 1ps

interface bbd_in_if
  import bbd_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bbd_out_if
  import bbd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== design/bbd_dabble.sv =====
// bbd_dabble: bit-serial double dabble core, magnitude shifts in msb first,
// bcd digits shift out most significant first; depends on bbd_pkg
`timescale 1ns / 1ps

module bbd_dabble
  import bbd_pkg::*;
#(
  parameter int MAG_W = 64,
  parameter int NDIG  = 20
) (
  input  logic             clk,
  input  bbd_ctrl_t        ctrl,
  input  logic [MAG_W-1:0] load_mag,
  output logic [3:0]       top_digit
);

  localparam int BCD_W = 4 * NDIG;

  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;

  // add 3 to every digit of 5 or more before the doubling shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      mag_nxt = load_mag;
      bcd_nxt = '0;
    end else if (ctrl.step) begin
      mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[MAG_W-1]};
    end else if (ctrl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

// ===== design/signed_binary_to_decimal_ascii_unit.sv =====
// signed_binary_to_decimal_ascii_unit: signed integer to decimal ascii text, one char a transfer
// depends on bbd_pkg, bbd_ifs and bbd_dabble
//
//   channel | dir | fields                 | transfer
//   in_ch   | in  | value[63:0] signed     | valid && ready
//   out_ch  | out | char_code[5:0], last   | valid && ready
//
// one item passes through acceptance, VALUE_WIDTH double dabble steps, a leading zero pass
// that drops zeros but keeps the units digit, then one character per cycle (sign plus
// 1..NDIG-1 digits) when the output is free
// in_ch.ready is high only between items; the last character may still wait in the
// output register while the next value is taken
// out_ch stalls hold the sequencer in its sign and digit states; rst_n is synchronous and clears control state only
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_unit
  import bbd_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  bbd_in_if.sink    in_ch,
  bbd_out_if.source out_ch
);

  localparam int MAG_W     = VALUE_WIDTH;
  localparam int NDIG      = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W = $clog2(NDIG);

  bbd_state_t state_r, state_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic neg_r, neg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  bbd_ctrl_t        ctrl;
  logic [3:0]       top_digit;
  logic [MAG_W-1:0] raw;
  logic             raw_neg;
  logic [MAG_W-1:0] load_mag;
  logic             in_xfer;
  logic             slot_free;

  assign raw      = in_ch.value[VALUE_WIDTH-1:0];
  assign raw_neg  = raw[VALUE_WIDTH-1];
  // unsigned magnitude, so the most negative value maps to 2^(width-1)
  assign load_mag = raw_neg ? (~raw + {{(MAG_W-1){1'b0}}, 1'b1}) : raw;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  bbd_dabble #(
    .MAG_W (MAG_W),
    .NDIG  (NDIG)
  ) u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_mag  (load_mag),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    neg_nxt       = neg_r;
    ctrl          = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ctrl.load   = 1'b1;
          neg_nxt     = raw_neg;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_WIDTH - 1);
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.step = 1'b1;
        if (bit_cnt_r == '0) begin
          dig_cnt_nxt = DIG_CNT_W'(NDIG - 1);
          state_nxt   = ST_SKIP;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        end
      end
      ST_SKIP: begin
        // drop leading zeros but keep the units digit
        if (top_digit == 4'd0 && dig_cnt_r != '0) begin
          ctrl.shift  = 1'b1;
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          ctrl.shift    = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {2'b00, top_digit};
          out_last_nxt  = (dig_cnt_r == '0);
          if (dig_cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;

  // every emitted digit must be a valid bcd digit
  a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIGIT |-> top_digit <= 4'd9)
    else $error("non-bcd digit reached the output");

  // a transfer in always starts the conversion loop
  a_load_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_CONV)
    else $error("accepted value did not start conversion");

  // a nonzero leading digit ends zero suppression
  a_skip_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SKIP && top_digit != 4'd0 |=> state_r == ST_SIGN || state_r == ST_DIGIT)
    else $error("leading zero suppression ran past a nonzero digit");

endmodule

// ===== test/signed_binary_to_decimal_ascii_unit_tb.sv =====
// signed_binary_to_decimal_ascii_unit_tb: checks the decimal ascii text for each signed value
// depends on bbd_pkg, bbd_ifs and signed_binary_to_decimal_ascii_unit
// a scoreboard predicts the characters per transfer; random idling and stalls on both sides
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_unit_tb;
  import bbd_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } ascii_char_t;

  class ascii_scoreboard;
    ascii_char_t pending_chars[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    // decimal text of one two's complement value, sign first
    function void note_value(logic [IN_W-1:0] value);
      logic [IN_W-1:0] magnitude;
      logic [3:0]      digits[20];
      bit              negative;
      int              ndig;
      ascii_char_t     ch;
      negative  = value[IN_W-1];
      magnitude = negative ? (~value + IN_W'(1)) : value;
      ndig      = 0;
      do begin
        digits[ndig] = 4'(magnitude % 10);
        magnitude    = magnitude / 10;
        ndig++;
      end while (magnitude != 0);
      if (negative) begin
        ch.char_code = ASCII_MINUS;
        ch.last      = 1'b0;
        pending_chars.push_back(ch);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        ch.char_code = ASCII_ZERO + CHAR_W'(digits[i]);
        ch.last      = (i == 0);
        pending_chars.push_back(ch);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] char_code, logic last);
      ascii_char_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected char %0d last %0b", $realtime, char_code, last);
      end else begin
        want = pending_chars.pop_front();
        if (want.char_code !== char_code || want.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: char mismatch, expected %0d last %0b, got %0d last %0b",
                     $realtime, want.char_code, want.last, char_code, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bbd_in_if  in_if ();
  bbd_out_if out_if ();

  signed_binary_to_decimal_ascii_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  ascii_scoreboard sb;
  int idle_pct;
  int stall_pct;
  bit long_hold;
  bit hold_served;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // input and output transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_value(in_if.value);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_char(out_if.char_code, out_if.last);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_served) begin
        hold_served = 1'b1;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_value(input logic [IN_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // advance the clock first so the monitor has noted the last transfer
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_chars.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] random_value();
    logic [IN_W-1:0] value;
    logic [IN_W-1:0] pow;
    int              kind;
    kind  = $urandom_range(9);
    value = {$urandom, $urandom};
    case (kind)
      4, 5, 6: begin
        // random magnitude length
        value = value >> $urandom_range(63);
        if ($urandom_range(1)) value = ~value + IN_W'(1);
      end
      7: begin
        value = IN_W'($urandom_range(1000));
        if ($urandom_range(1)) value = ~value + IN_W'(1);
      end
      8, 9: begin
        // around a power of ten, where the digit count changes
        pow = IN_W'(1);
        repeat ($urandom_range(18)) pow = pow * IN_W'(10);
        value = pow - IN_W'(1) + IN_W'($urandom_range(2));
        if ($urandom_range(1)) value = ~value + IN_W'(1);
      end
      default: ;
    endcase
    return value;
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_value(random_value());
    drain_results();
  endtask

  initial begin
    logic signed [IN_W-1:0] directed[$];
    sb        = new();
    idle_pct  = 0;
    stall_pct = 0;
    long_hold = 1'b0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      64'sd0, 64'sd1, -64'sd1, 64'sd9, 64'sd10, -64'sd10, 64'sd99, 64'sd100,
      64'sd12345, -64'sd98765,
      64'sd2147483647, -64'sd2147483648, -64'sd2147483649, 64'sd4294967296,
      64'sd999999999999999999, 64'sd1000000000000000000,
      -64'sd999999999999999999, -64'sd1000000000000000000,
      64'sh7fff_ffff_ffff_ffff, 64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0001,
      64'sh5555_5555_5555_5555, 64'shaaaa_aaaa_aaaa_aaaa
    };
    foreach (directed[i]) send_value(directed[i]);
    drain_results();

    // long receiver hold-off while the sender keeps offering
    idle_pct  = 0;
    stall_pct = 0;
    long_hold = 1'b1;
    repeat (12) send_value(random_value());
    drain_results();
    repeat (20) @(posedge clk);

    random_phase(125, 0, 0);
    random_phase(125, 80, 0);
    random_phase(125, 0, 80);
    random_phase(125, 24, 24);

    repeat (150) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
